// ----- hw/rtl/amcf_pkg.sv -----
// ----------------------------------------------------------------------------
// amcf_pkg
// Shared types, constants and the frame byte function of the command framer.
// ----------------------------------------------------------------------------
package amcf_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
   localparam int unsigned CMD_W               = 24;  // code, arg high, arg low
   localparam int unsigned GAP_W               = 16;
   localparam int unsigned POS_W               = 3;

   localparam logic [7:0]       FRAME_SOF     = 8'h7E;
   localparam logic [7:0]       FRAME_EOF     = 8'hEF;
   localparam logic [7:0]       FEEDBACK_BYTE = 8'h00;
   localparam logic [GAP_W-1:0] GAP_RESET     = 16'd200;

   // byte slots of one frame
   localparam logic [POS_W-1:0] POS_SOF     = 3'd0;
   localparam logic [POS_W-1:0] POS_CODE    = 3'd1;
   localparam logic [POS_W-1:0] POS_FEEDBK  = 3'd2;
   localparam logic [POS_W-1:0] POS_ARG_HI  = 3'd3;
   localparam logic [POS_W-1:0] POS_ARG_LO  = 3'd4;
   localparam logic [POS_W-1:0] POS_CHK_HI  = 3'd5;
   localparam logic [POS_W-1:0] POS_CHK_LO  = 3'd6;
   localparam logic [POS_W-1:0] POS_EOF     = 3'd7;

   typedef enum logic [1:0] {
      FUNC_ENQUEUE = 2'd0,
      FUNC_READY   = 2'd1,
      FUNC_TICK    = 2'd2
   } amcf_func_type;

   typedef struct packed {
      logic             push;
      logic             pop;
      logic [CMD_W-1:0] push_data;
   } amcf_qctl_type;

   typedef struct packed {
      logic             empty;
      logic             full;
      logic [CMD_W-1:0] head_data;
   } amcf_qstat_type;

   typedef struct packed {
      logic       busy;
      logic       accepted;
      logic       frame_end;
      logic [7:0] tx_byte;
      logic       tx_valid;
   } amcf_result_type;

   // frame word layout: code [23:16], arg high [15:8], arg low [7:0]
   function automatic logic [7:0] amcf_frame_byte(input logic [CMD_W-1:0] frame,
                                                  input logic [POS_W-1:0] pos);
      logic [15:0] sum;
      logic [15:0] chk;
      logic [7:0]  res;
      sum = 16'(frame[23:16]) + 16'(FEEDBACK_BYTE) + 16'(frame[15:8])
            + 16'(frame[7:0]);
      chk = 16'(~sum + 16'd1);
      case (pos)
         POS_SOF:    res = FRAME_SOF;
         POS_CODE:   res = frame[23:16];
         POS_FEEDBK: res = FEEDBACK_BYTE;
         POS_ARG_HI: res = frame[15:8];
         POS_ARG_LO: res = frame[7:0];
         POS_CHK_HI: res = chk[15:8];
         POS_CHK_LO: res = chk[7:0];
         default:    res = FRAME_EOF;
      endcase
      return res;
   endfunction

endpackage

// ----- hw/rtl/amcf_queue.sv -----
// ----------------------------------------------------------------------------
// amcf_queue
// Small circular queue of pending commands, head read directly.
// ----------------------------------------------------------------------------
module amcf_queue #(
   parameter int unsigned QUEUE_DEPTH = amcf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  amcf_pkg::amcf_qctl_type  ctl,
   output amcf_pkg::amcf_qstat_type stat
);
   import amcf_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned SUM_W = PTR_W + 1;

   logic [CMD_W-1:0] pending_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] tail_sum;
   logic [PTR_W-1:0] tail;

   // tail = (head + count) mod depth, sum stays below twice the depth
   always_comb begin
      tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
      if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
      end
      tail = tail_sum[PTR_W-1:0];
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctl.pop) begin
         head_in  = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end else if (ctl.push) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         pending_ff[tail] <= ctl.push_data;
      end
   end

   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign stat.head_data = pending_ff[head_ff];

endmodule

// ----- hw/rtl/amcf_core.sv -----
// ----------------------------------------------------------------------------
// amcf_core
// Link state machine: frame start, byte sequencing, gap timer, result.
// ----------------------------------------------------------------------------
module amcf_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            item_take,
   input  logic [1:0]                      func,
   input  logic [amcf_pkg::CMD_W-1:0]      cmd_word,
   input  logic                            csr_we,
   input  logic [amcf_pkg::GAP_W-1:0]      csr_wdata,
   input  amcf_pkg::amcf_qstat_type        qstat,
   output amcf_pkg::amcf_qctl_type         qctl,
   output amcf_pkg::amcf_result_type       result
);
   import amcf_pkg::*;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_SEND = 2'd1,
      PHASE_GAP  = 2'd2
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [CMD_W-1:0] frame_ff, frame_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [GAP_W-1:0] gap_cnt_ff, gap_cnt_in;
   logic [GAP_W-1:0] gap_ticks_ff;

   always_comb begin
      phase_in   = phase_ff;
      frame_in   = frame_ff;
      pos_in     = pos_ff;
      gap_cnt_in = gap_cnt_ff;
      qctl       = '{push: 1'b0, pop: 1'b0, push_data: cmd_word};
      result     = '0;
      if (item_take) begin
         case (amcf_func_type'(func))
            FUNC_ENQUEUE: begin
               // idle implies an empty queue: start the frame at once
               if (phase_ff == PHASE_IDLE) begin
                  result.accepted = 1'b1;
                  frame_in        = cmd_word;
                  pos_in          = POS_SOF;
                  phase_in        = PHASE_SEND;
               end else if (!qstat.full) begin
                  result.accepted = 1'b1;
                  qctl.push       = 1'b1;
               end
            end
            FUNC_READY: begin
               if (phase_ff == PHASE_SEND) begin
                  result.tx_valid = 1'b1;
                  result.tx_byte  = amcf_frame_byte(frame_ff, pos_ff);
                  if (pos_ff == POS_EOF) begin
                     result.frame_end = 1'b1;
                     pos_in           = POS_SOF;
                     phase_in         = PHASE_GAP;
                     gap_cnt_in       = gap_ticks_ff;
                  end else begin
                     pos_in = pos_ff + 1'b1;
                  end
               end
            end
            FUNC_TICK: begin
               if (phase_ff == PHASE_GAP) begin
                  if (gap_cnt_ff <= GAP_W'(1)) begin
                     gap_cnt_in = '0;
                     if (qstat.empty) begin
                        phase_in = PHASE_IDLE;
                     end else begin
                        qctl.pop = 1'b1;
                        frame_in = qstat.head_data;
                        pos_in   = POS_SOF;
                        phase_in = PHASE_SEND;
                     end
                  end else begin
                     gap_cnt_in = gap_cnt_ff - 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      result.busy = (phase_in != PHASE_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         frame_ff     <= '0;
         pos_ff       <= '0;
         gap_cnt_ff   <= '0;
         gap_ticks_ff <= GAP_RESET;
      end else begin
         phase_ff   <= phase_in;
         frame_ff   <= frame_in;
         pos_ff     <= pos_in;
         gap_cnt_ff <= gap_cnt_in;
         if (csr_we) begin
            gap_ticks_ff <= csr_wdata;
         end
      end
   end

endmodule

// ----- hw/rtl/audio_module_command_framer_top.sv -----
// ----------------------------------------------------------------------------
// audio_module_command_framer_top
// Queues module commands and sends each as an 8-byte serial frame.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake            payload
//   req      in   req_tvalid/tready    tuser func, tdata cmd/arg_high/arg_low
//   rsp      out  rsp_tvalid/tready    tdata byte, tuser flags, tlast frame end
//   csr      in   csr_we               csr_wdata = gap ticks after each frame
//
// Every req item gives exactly one rsp item, valid in the cycle after it is taken.
// One item per cycle unless a held rsp item stalls req: state updates in a single pass into the rsp register.
// req_tready drops only while a rsp item is held by a low rsp_tready.
// Synchronous reset: queue empty, link idle, gap ticks back to 200.
//
// Frame: 7E, code, 00, arg high, arg low, checksum high, checksum low, EF.
// Checksum is the 16-bit two's complement of code + 00 + arg high + arg low.
// ----------------------------------------------------------------------------
module audio_module_command_framer_top #(
   parameter int unsigned QUEUE_DEPTH = amcf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [23:0]                 req_tdata,  // cmd_code, arg_high, arg_low
   input  logic [1:0]                  req_tuser,  // func
   // result channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,  // tx_byte
   output logic [2:0]                  rsp_tuser,  // tx_valid, accepted, busy_res
   output logic                        rsp_tlast,  // frame_end
   // configuration
   input  logic                        csr_we,
   input  logic [amcf_pkg::GAP_W-1:0]  csr_wdata
);
   import amcf_pkg::*;

   amcf_qctl_type    qctl;
   amcf_qstat_type   qstat;
   amcf_result_type  result;
   amcf_result_type  rsp_ff;
   logic             rsp_valid_ff;
   logic             item_take;
   logic [CMD_W-1:0] cmd_word;

   // take a new item whenever the rsp register is empty or drains now
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign item_take  = req_tvalid && req_tready;

   // internal word: code high, arg low in the bottom byte
   assign cmd_word = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};

   amcf_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .ctl  (qctl),
      .stat (qstat)
   );

   amcf_core u_core (
      .clock    (clock),
      .reset    (reset),
      .item_take(item_take),
      .func     (req_tuser),
      .cmd_word (cmd_word),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .qstat    (qstat),
      .qctl     (qctl),
      .result   (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_tready) begin
         rsp_valid_ff <= item_take;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.tx_byte;
   assign rsp_tuser  = {rsp_ff.busy, rsp_ff.accepted, rsp_ff.tx_valid};
   assign rsp_tlast  = rsp_ff.frame_end;

endmodule

// ----- hw/rtl/amcf_checker.sv -----
// ----------------------------------------------------------------------------
// amcf_checker
// Port-level checks of the command framer, bound to the top level.
// ----------------------------------------------------------------------------
module amcf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import amcf_pkg::*;

   // every taken request produces a result on the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("taken item gave no result");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
      && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // frame end comes only with an emitted end marker
   a_eof_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0] && rsp_tdata == FRAME_EOF)
      else $error("frame end without end marker");

   // a queued command leaves the link busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[2] && !rsp_tuser[0])
      else $error("accepted command with idle link");

   // no result right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind audio_module_command_framer_top amcf_checker u_amcf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast)
);

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the command framer: requests go in on the req stream with bursts and
// gaps, results are taken on the rsp stream under changing back-pressure, and
// every result is compared field by field with a local copy of the framer's
// queue, frame and gap logic.
// ----------------------------------------------------------------------------
module testbench;
   import amcf_pkg::*;

   localparam int unsigned QDEPTH    = QUEUE_DEPTH_DEFAULT;
   localparam int unsigned QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int unsigned RUN_LIMIT = 200_000;     // cycles
   localparam logic [1:0]  FUNC_UNUSED = 2'd3;       // func code the block ignores

   typedef enum logic [1:0] {
      LINK_IDLE,
      LINK_SEND,
      LINK_GAP
   } link_state_type;

   typedef struct {
      logic [1:0] func;
      logic [7:0] code;
      logic [7:0] arg_hi;
      logic [7:0] arg_lo;
   } cmd_request_type;

   // ------------------------------------------------------------------------
   // DUT ports; every input has a known value from time zero
   // ------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // cmd_code, arg_high, arg_low
   logic [1:0]  req_tuser  = '0;   // func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // tx_byte
   logic [2:0]  rsp_tuser;         // tx_valid, accepted, busy_res
   logic        rsp_tlast;         // frame_end
   logic        csr_we     = 1'b0;
   logic [GAP_W-1:0] csr_wdata = '0;

   audio_module_command_framer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Bookkeeping shared between stimulus, driver and monitor
   // ------------------------------------------------------------------------
   cmd_request_type command_backlog[$];   // items not yet driven
   amcf_result_type awaited_rsp[$];       // predicted results, oldest first
   int unsigned     issued_count   = 0;   // items put in the backlog
   int unsigned     taken_count    = 0;   // items accepted by the DUT
   int unsigned     rsp_seen       = 0;
   int unsigned     mismatch_count = 0;
   int unsigned     cycle_count    = 0;
   logic            req_taken      = 1'b0;  // handshake at the last rising edge

   // ------------------------------------------------------------------------
   // Framer state as predicted by the testbench
   // ------------------------------------------------------------------------
   logic [23:0]      cmd_slot[QDEPTH];    // {code, arg_hi, arg_lo}
   int unsigned      q_head;
   int unsigned      q_count;
   link_state_type   link;
   logic [23:0]      cur_frame;
   logic [2:0]       byte_pos;
   logic [GAP_W-1:0] gap_count;
   logic [GAP_W-1:0] gap_setting;

   task automatic reset_framer();
      q_head      = 0;
      q_count     = 0;
      link        = LINK_IDLE;
      cur_frame   = '0;
      byte_pos    = '0;
      gap_count   = '0;
      gap_setting = GAP_RESET;
   endtask

   // pop the queue head into the frame register, or drop back to idle
   task automatic load_next_frame();
      if (q_count == 0) begin
         link = LINK_IDLE;
      end else begin
         cur_frame = cmd_slot[QPTR_W'(q_head)];
         q_head    = (q_head + 1) % QDEPTH;
         q_count   = q_count - 1;
         byte_pos  = POS_SOF;
         link      = LINK_SEND;
      end
   endtask

   task automatic advance_framer(input cmd_request_type item, output amcf_result_type res);
      logic [15:0] chk;
      res = '0;
      case (item.func)
         FUNC_ENQUEUE: begin
            if (q_count < QDEPTH) begin
               cmd_slot[QPTR_W'((q_head + q_count) % QDEPTH)] =
                  {item.code, item.arg_hi, item.arg_lo};
               q_count      = q_count + 1;
               res.accepted = 1'b1;
               if (link == LINK_IDLE) load_next_frame();
            end
         end
         FUNC_READY: begin
            if (link == LINK_SEND) begin
               chk = 16'h0000 - (16'(cur_frame[23:16]) + 16'(FEEDBACK_BYTE)
                                 + 16'(cur_frame[15:8]) + 16'(cur_frame[7:0]));
               res.tx_valid = 1'b1;
               case (byte_pos)
                  POS_SOF:    res.tx_byte = FRAME_SOF;
                  POS_CODE:   res.tx_byte = cur_frame[23:16];
                  POS_FEEDBK: res.tx_byte = FEEDBACK_BYTE;
                  POS_ARG_HI: res.tx_byte = cur_frame[15:8];
                  POS_ARG_LO: res.tx_byte = cur_frame[7:0];
                  POS_CHK_HI: res.tx_byte = chk[15:8];
                  POS_CHK_LO: res.tx_byte = chk[7:0];
                  default:    res.tx_byte = FRAME_EOF;
               endcase
               if (byte_pos == POS_EOF) begin
                  res.frame_end = 1'b1;
                  byte_pos      = POS_SOF;
                  link          = LINK_GAP;
                  gap_count     = gap_setting;
               end else begin
                  byte_pos = byte_pos + 3'd1;
               end
            end
         end
         FUNC_TICK: begin
            // a gap setting of zero ends on the first tick, same as one
            if (link == LINK_GAP) begin
               if (gap_count <= 1) begin
                  gap_count = '0;
                  load_next_frame();
               end else begin
                  gap_count = gap_count - 1'b1;
               end
            end
         end
         default: ;   // unused func: no state change
      endcase
      res.busy = (link != LINK_IDLE);
   endtask

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("[%0t] rsp item %0d %s: got %0h, want %0h", $realtime, rsp_seen, what,
               got, want);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // Monitor: check the result first, then predict for the item taken at
   // this same edge (its result can appear in the next cycle at the earliest).
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      amcf_result_type want;
      amcf_result_type got;
      cmd_request_type item;
      if (reset) begin
         reset_framer();
         req_taken = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_rsp.size() == 0) begin
               report_mismatch("unexpected item, tdata", 32'(rsp_tdata), 0);
            end else begin
               want          = awaited_rsp.pop_front();
               got.tx_valid  = rsp_tuser[0];
               got.accepted  = rsp_tuser[1];
               got.busy      = rsp_tuser[2];
               got.tx_byte   = rsp_tdata;
               got.frame_end = rsp_tlast;
               if (got.tx_valid !== want.tx_valid)
                  report_mismatch("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
               if (got.tx_byte !== want.tx_byte)
                  report_mismatch("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
               if (got.frame_end !== want.frame_end)
                  report_mismatch("frame_end", 32'(got.frame_end), 32'(want.frame_end));
               if (got.accepted !== want.accepted)
                  report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
               if (got.busy !== want.busy)
                  report_mismatch("busy_res", 32'(got.busy), 32'(want.busy));
            end
            rsp_seen++;
         end
         if (csr_we) gap_setting = csr_wdata;
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            item.func   = req_tuser;
            item.code   = req_tdata[7:0];
            item.arg_hi = req_tdata[15:8];
            item.arg_lo = req_tdata[23:16];
            advance_framer(item, want);
            awaited_rsp.push_back(want);
            taken_count++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Driver: bursts of random length, random idle gaps in between, some
   // bursts with no gap at all. Changes only on the falling edge.
   // ------------------------------------------------------------------------
   int unsigned burst_left = 1;
   int unsigned idle_left  = 0;

   always @(negedge clock) begin
      cmd_request_type nxt;
      if (!reset && (!req_tvalid || req_taken)) begin
         if (idle_left > 0 || command_backlog.size() == 0) begin
            if (idle_left > 0) idle_left--;
            req_tvalid <= 1'b0;
         end else begin
            nxt = command_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= nxt.func;
            req_tdata  <= {nxt.arg_lo, nxt.arg_hi, nxt.code};
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: back-pressure mode switches after each random span between
   // always ready, coin flip, a fixed 4-of-5 pattern and mostly stalled.
   // ------------------------------------------------------------------------
   int unsigned stall_mode = 0;
   int unsigned stall_span = 0;
   int unsigned rx_phase   = 0;

   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_span = $urandom_range(20, 150);
      end else begin
         stall_span--;
      end
      rx_phase++;
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= (rx_phase % 5) != 0;
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  awaited_rsp.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic add_request(input logic [1:0] func, input logic [7:0] code,
                              input logic [7:0] arg_hi, input logic [7:0] arg_lo);
      cmd_request_type item;
      item.func   = func;
      item.code   = code;
      item.arg_hi = arg_hi;
      item.arg_lo = arg_lo;
      command_backlog.push_back(item);
      issued_count++;
   endtask

   // byte with a bias toward both extremes
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // sender holds off until every item is taken and every result checked;
   // then it waits on so that nothing is in flight inside the block
   task automatic wait_until_drained();
      do @(negedge clock); while (taken_count != issued_count || awaited_rsp.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_gap(input logic [GAP_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly well-formed traffic: a handful of enqueues (sometimes up to two more
   // than the queue holds), then for each frame eight readies with the odd
   // stray item mixed in, then enough ticks to close the gap. Now and then
   // a ready lands in the gap, and some items are plain noise.
   task automatic add_random_traffic(input int unsigned gap, input int budget);
      int unsigned n;
      int unsigned t;
      while (budget > 0) begin
         if ($urandom_range(0, 9) == 0) begin
            add_request(2'($urandom_range(0, 3)), pick_byte(), pick_byte(), pick_byte());
            budget--;
         end else begin
            n = $urandom_range(1, QDEPTH + 2);
            repeat (n) begin
               add_request(FUNC_ENQUEUE, pick_byte(), pick_byte(), pick_byte());
               budget--;
            end
            for (int f = 0; f < n; f++) begin
               for (int b = 0; b < 8; b++) begin
                  if ($urandom_range(0, 15) == 0) begin
                     case ($urandom_range(0, 2))
                        0:       add_request(FUNC_ENQUEUE, pick_byte(), pick_byte(),
                                             pick_byte());
                        1:       add_request(FUNC_TICK, pick_byte(), pick_byte(), pick_byte());
                        default: add_request(FUNC_UNUSED, pick_byte(), pick_byte(),
                                             pick_byte());
                     endcase
                     budget--;
                  end
                  add_request(FUNC_READY, pick_byte(), pick_byte(), pick_byte());
                  budget--;
               end
               t = (gap == 0) ? 1 : gap;
               if ($urandom_range(0, 3) == 0) begin
                  // ready while the gap is still running
                  repeat (t - 1) add_request(FUNC_TICK, pick_byte(), pick_byte(), pick_byte());
                  add_request(FUNC_READY, pick_byte(), pick_byte(), pick_byte());
                  add_request(FUNC_TICK, pick_byte(), pick_byte(), pick_byte());
                  budget--;
               end else begin
                  repeat (t) add_request(FUNC_TICK, pick_byte(), pick_byte(), pick_byte());
               end
               budget -= int'(t);
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      int unsigned g;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, gap at its reset value of 200: ready, tick and the unused
      // func on an idle link; enqueue on idle starts at once; extremes of
      // code and arguments; the queue fills and one request is refused.
      add_request(FUNC_READY, 8'h00, 8'h00, 8'h00);
      add_request(FUNC_TICK, 8'hFF, 8'hFF, 8'hFF);
      add_request(FUNC_UNUSED, 8'hA5, 8'h5A, 8'hC3);
      add_request(FUNC_ENQUEUE, 8'h00, 8'h00, 8'h00);
      add_request(FUNC_ENQUEUE, 8'hFF, 8'hFF, 8'hFF);
      add_request(FUNC_ENQUEUE, 8'h7E, 8'hEF, 8'h01);
      add_request(FUNC_ENQUEUE, 8'h80, 8'h55, 8'hAA);
      add_request(FUNC_ENQUEUE, 8'h01, 8'h02, 8'h03);
      add_request(FUNC_ENQUEUE, 8'h12, 8'h34, 8'h56);   // queue full: refused
      add_request(FUNC_TICK, 8'h00, 8'h00, 8'h00);      // tick while sending
      repeat (8) add_request(FUNC_READY, pick_byte(), pick_byte(), pick_byte());
      add_request(FUNC_READY, 8'h00, 8'h00, 8'h00);     // ready in the gap
      add_request(FUNC_UNUSED, 8'hFF, 8'hFF, 8'hFF);
      repeat (GAP_RESET - 1) add_request(FUNC_TICK, pick_byte(), pick_byte(), pick_byte());
      add_request(FUNC_READY, 8'h00, 8'h00, 8'h00);     // one tick still to go
      add_request(FUNC_TICK, 8'h00, 8'h00, 8'h00);      // end of gap, next frame
      repeat (8) add_request(FUNC_READY, pick_byte(), pick_byte(), pick_byte());
      wait_until_drained();

      // shortest gap; three frames are still queued from the directed part
      write_gap(16'd1);
      add_random_traffic(1, 100);
      wait_until_drained();

      // zero gap acts as one tick
      write_gap(16'd0);
      add_random_traffic(0, 70);
      wait_until_drained();

      g = $urandom_range(2, 12);
      write_gap(GAP_W'(g));
      add_random_traffic(g, 90);
      wait_until_drained();

      g = $urandom_range(13, 40);
      write_gap(GAP_W'(g));
      add_random_traffic(g, 70);
      wait_until_drained();

      // Longest gap, done last so its count never has to run out. A one-tick
      // gap and a few rounds of readies and ticks bring the link to idle;
      // then one frame loads the full count, a ready and an enqueue land in
      // the gap and the link stays busy a few dozen ticks later.
      write_gap(16'd1);
      repeat (40) add_request(FUNC_TICK, 8'h00, 8'h00, 8'h00);
      repeat (QDEPTH + 1) begin
         repeat (8) add_request(FUNC_READY, 8'h00, 8'h00, 8'h00);
         add_request(FUNC_TICK, 8'h00, 8'h00, 8'h00);
      end
      wait_until_drained();
      write_gap(16'hFFFF);
      add_request(FUNC_ENQUEUE, 8'hC0, 8'hFF, 8'h00);
      repeat (8) add_request(FUNC_READY, pick_byte(), pick_byte(), pick_byte());
      repeat (32) add_request(FUNC_TICK, pick_byte(), pick_byte(), pick_byte());
      add_request(FUNC_READY, 8'h00, 8'h00, 8'h00);
      add_request(FUNC_ENQUEUE, 8'h3F, 8'h00, 8'hFF);
      add_request(FUNC_TICK, 8'h00, 8'h00, 8'h00);
      add_request(FUNC_READY, 8'h00, 8'h00, 8'h00);

      // wait for the last results, then a short quiet stretch for strays
      wait_until_drained();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
